// File: rtl/core/gfba_pkg.sv
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared widths, reset values, codes and controller/datapath bundles of the
// grouped free-block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

  localparam int ID_W   = 10;
  localparam int TB_W   = 11;
  localparam int GL_W   = 3;
  localparam int HC_W   = 3;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 1;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_MAX_GROUP  = 4;

  localparam logic [TB_W-1:0] TOTAL_BLOCKS_RST = 11'd1000;
  localparam logic [GL_W-1:0] GROUP_LIMIT_RST  = 3'd3;

  localparam logic [CIDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_GROUP_LIMIT  = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic clr;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic need_load;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/gfba_req_if.sv
// ----------------------------------------------------------------------------
// gfba_req_if
// Request channel: action and block number, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gfba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [gfba_pkg::ID_W-1:0] block_id;

  modport source (output valid, output action, output block_id, input ready);
  modport sink   (input valid, input action, input block_id, output ready);
endinterface

// File: rtl/core/gfba_rsp_if.sv
// ----------------------------------------------------------------------------
// gfba_rsp_if
// Response channel: status, granted block and head count, valid/ready.
// ----------------------------------------------------------------------------
interface gfba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [gfba_pkg::ID_W-1:0] granted_block;
  logic [gfba_pkg::HC_W-1:0] head_count;

  modport source (output valid, output status, output granted_block, output head_count,
                  input ready);
  modport sink   (input valid, input status, input granted_block, input head_count,
                  output ready);
endinterface

// File: rtl/core/grouped_free_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Grouped-link free-block allocator: cached head group plus record store.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transfer: action (allocate or free) and the
//   block number to free. rsp_o returns one response per request: status,
//   granted block and the head count after the request.
//   total_blocks and group_limit are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; the user writes them only while idle, not enforced by the block.
//   Response: registered in the cycle after the request transfer; an allocate
//   that empties the head reloads the next group from the record store and
//   answers from ST_LOAD (one record read, then the clear write).
//   Throughput: one request per cycle while rsp_o drains; none during a reload.
//   The record store takes one write port and one registered read port.
//   Reset: head group empty, registers at their defaults; then the record
//   store is swept to zero, every entry in turn, with req_i.ready low.
//   A stalled response stays in the output register; one new request is
//   taken only when that register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator #(
  parameter int MAX_BLOCKS = gfba_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_GROUP  = gfba_pkg::DEF_MAX_GROUP
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfba_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [gfba_pkg::CFG_W-1:0]  cfg_data_i,
  gfba_req_if.sink                    req_i,
  gfba_rsp_if.source                  rsp_o
);

  localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(MAX_GROUP + 1);
  localparam int REC_W = MAX_GROUP * gfba_pkg::ID_W + 2 * CW;

  gfba_pkg::cmd_t   cmd;
  gfba_pkg::sts_t   sts;
  logic             in_ready;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [REC_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [REC_W-1:0] mem_rdata;

  assign req_i.ready = in_ready;

  gfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gfba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_GROUP  (MAX_GROUP)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .action_i     (req_i.action),
    .block_id_i   (req_i.block_id),
    .rsp_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .status_o     (rsp_o.status),
    .granted_o    (rsp_o.granted_block),
    .head_count_o (rsp_o.head_count),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  gfba_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_BLOCKS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: rtl/core/gfba_ram.sv
// ----------------------------------------------------------------------------
// gfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfba_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gfba_ctrl.sv
// ----------------------------------------------------------------------------
// gfba_ctrl
// Sequencer: record-store clear sweep, request accept, group reload.
// ----------------------------------------------------------------------------
module gfba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gfba_pkg::sts_t sts_i,
  output gfba_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_o.clr   = 1'b0;
    cmd_o.exec  = 1'b0;
    cmd_o.load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.need_load) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (state_q == ST_IDLE))
    else $error("reload lasted more than one cycle");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request ready during clear sweep");

  a_reload_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.need_load) |=> (state_q == ST_LOAD))
    else $error("group reload not started");
`endif

endmodule

// File: rtl/core/gfba_dp.sv
// ----------------------------------------------------------------------------
// gfba_dp
// Head group registers, config registers, record-store access, result reg.
// ----------------------------------------------------------------------------
module gfba_dp #(
  parameter int MAX_BLOCKS = gfba_pkg::DEF_MAX_BLOCKS,
  parameter int MAX_GROUP  = gfba_pkg::DEF_MAX_GROUP,
  localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW    = $clog2(MAX_GROUP + 1),
  localparam int REC_W = MAX_GROUP * gfba_pkg::ID_W + 2 * CW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfba_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [gfba_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        action_i,
  input  logic [gfba_pkg::ID_W-1:0]   block_id_i,
  input  logic                        rsp_ready_i,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [gfba_pkg::ID_W-1:0]   granted_o,
  output logic [gfba_pkg::HC_W-1:0]   head_count_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [REC_W-1:0]            mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [REC_W-1:0]            mem_rdata_i,
  input  gfba_pkg::cmd_t              cmd_i,
  output gfba_pkg::sts_t              sts_o
);

  localparam int IW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CMPW = (CW > gfba_pkg::GL_W) ? CW : gfba_pkg::GL_W;
  localparam int ID_W = gfba_pkg::ID_W;

  logic [ID_W-1:0]           ids_q [MAX_GROUP];
  logic [ID_W-1:0]           ids_d [MAX_GROUP];
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [CW-1:0]             nxt_q, nxt_d;
  logic [gfba_pkg::TB_W-1:0] tb_q;
  logic [gfba_pkg::GL_W-1:0] gl_q;
  logic [AW-1:0]             clr_cnt_q;
  logic                      out_valid_q, out_valid_d;
  gfba_pkg::status_e         out_status_q, out_status_d;
  logic [ID_W-1:0]           out_grant_q, out_grant_d;
  logic [gfba_pkg::HC_W-1:0] out_hc_q, out_hc_d;

  logic [CMPW-1:0]  eff_lim;
  logic             full;
  logic             id_bad;
  logic             head0_ok;
  logic [ID_W-1:0]  r_ids [MAX_GROUP];
  logic [CW-1:0]    r_cnt;
  logic [CW-1:0]    r_nxt;
  logic [REC_W-1:0] wrec;

  always_comb begin
    if (gl_q == '0) begin
      eff_lim = CMPW'(1);
    end else if (32'(gl_q) > MAX_GROUP) begin
      eff_lim = CMPW'(MAX_GROUP);
    end else begin
      eff_lim = CMPW'(gl_q);
    end
  end

  assign full     = CMPW'(cnt_q) >= eff_lim;
  assign id_bad   = ({1'b0, block_id_i} >= tb_q) || (32'(block_id_i) >= MAX_BLOCKS);
  assign head0_ok = 32'(ids_q[0]) < MAX_BLOCKS;

  always_comb begin
    for (int i = 0; i < MAX_GROUP; i++) begin
      r_ids[i] = mem_rdata_i[2*CW + i*ID_W +: ID_W];
      wrec[2*CW + i*ID_W +: ID_W] = ids_q[i];
    end
    r_cnt = mem_rdata_i[CW +: CW];
    r_nxt = mem_rdata_i[0 +: CW];
    wrec[CW +: CW] = cnt_q;
    wrec[0 +: CW]  = nxt_q;
  end

  assign sts_o.need_load = (action_i == gfba_pkg::ACT_ALLOC) && (cnt_q == CW'(1)) && head0_ok;
  assign sts_o.clr_last  = (clr_cnt_q == AW'(MAX_BLOCKS - 1));
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  assign mem_raddr_o = AW'(ids_q[0]);

  always_comb begin
    ids_d        = ids_q;
    cnt_d        = cnt_q;
    nxt_d        = nxt_q;
    out_valid_d  = out_valid_q && !rsp_ready_i;
    out_status_d = out_status_q;
    out_grant_d  = out_grant_q;
    out_hc_d     = out_hc_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = clr_cnt_q;
    mem_wdata_o  = '0;

    if (cmd_i.clr) begin
      mem_we_o = 1'b1;
    end

    if (cmd_i.exec) begin
      out_valid_d  = 1'b1;
      out_status_d = gfba_pkg::STATUS_OK;
      out_grant_d  = '0;
      if (action_i == gfba_pkg::ACT_ALLOC) begin
        if (cnt_q == '0) begin
          out_status_d = gfba_pkg::STATUS_EMPTY;
        end else if (cnt_q > CW'(1)) begin
          out_grant_d               = ids_q[IW'(cnt_q - CW'(1))];
          ids_d[IW'(cnt_q - CW'(1))] = '0;
          cnt_d                     = cnt_q - CW'(1);
        end else begin
          out_grant_d = ids_q[0];
          for (int i = 0; i < MAX_GROUP; i++) begin
            ids_d[i] = '0;
          end
          cnt_d = '0;
          nxt_d = '0;
        end
      end else begin
        if (id_bad) begin
          out_status_d = gfba_pkg::STATUS_RANGE;
        end else if (full) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(block_id_i);
          mem_wdata_o = wrec;
          for (int i = 0; i < MAX_GROUP; i++) begin
            ids_d[i] = '0;
          end
          ids_d[0] = block_id_i;
          nxt_d    = cnt_q;
          cnt_d    = CW'(1);
        end else begin
          ids_d[IW'(cnt_q)] = block_id_i;
          cnt_d             = cnt_q + CW'(1);
        end
      end
      out_hc_d = gfba_pkg::HC_W'(cnt_d);
    end

    if (cmd_i.load) begin
      ids_d = r_ids;
      cnt_d = (32'(r_cnt) > MAX_GROUP) ? CW'(MAX_GROUP) : r_cnt;
      nxt_d = r_nxt;
      mem_we_o     = 1'b1;
      mem_waddr_o  = AW'(ids_q[0]);
      mem_wdata_o  = '0;
      out_valid_d  = 1'b1;
      out_status_d = gfba_pkg::STATUS_OK;
      out_grant_d  = ids_q[0];
      out_hc_d     = gfba_pkg::HC_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_GROUP; i++) begin
        ids_q[i] <= '0;
      end
      cnt_q       <= '0;
      nxt_q       <= '0;
      tb_q        <= gfba_pkg::TOTAL_BLOCKS_RST;
      gl_q        <= gfba_pkg::GROUP_LIMIT_RST;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ids_q       <= ids_d;
      cnt_q       <= cnt_d;
      nxt_q       <= nxt_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gfba_pkg::CFG_TOTAL_BLOCKS: tb_q <= cfg_data_i[gfba_pkg::TB_W-1:0];
          gfba_pkg::CFG_GROUP_LIMIT:  gl_q <= cfg_data_i[gfba_pkg::GL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_grant_q  <= out_grant_d;
    out_hc_q     <= out_hc_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign granted_o    = out_grant_q;
  assign head_count_o = out_hc_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_GROUP)
    else $error("head count above group size");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !out_valid_q)
    else $error("reload with result register occupied");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (out_valid_q && out_status_q == gfba_pkg::STATUS_OK))
    else $error("reload produced no result");
`endif

endmodule
